// ===== rtl/sdf_pkg.sv =====
// Shared types, character codes and digit-extraction step for the decimal formatter.
package sdf_pkg;

  localparam int NUM_DIGITS = 5;
  localparam int MAX_CHARS  = 7;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_POINT = 7'h2E;

  // decimal weights, most significant digit first
  localparam logic [13:0] POW10 [NUM_DIGITS] = '{14'd10000, 14'd1000, 14'd100, 14'd10, 14'd1};

  typedef struct packed {
    logic signed [15:0] value;
    logic [2:0]         point_places;
  } req_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } rsp_t;

  // one request on its way through the digit pipeline
  typedef struct packed {
    logic                           neg;
    logic                           zero;
    logic [2:0]                     places;
    logic [15:0]                    rem;
    logic [NUM_DIGITS-1:0][3:0]     digits;  // [k] has weight 10^k
  } pipe_t;

  typedef struct packed {
    logic [MAX_CHARS-1:0][6:0] chars;        // [0] goes out first
    logic [2:0]                last;         // index of final char
  } fmt_t;

  // Peel one decimal digit off the remainder: nine parallel compares.
  function automatic pipe_t digit_step(pipe_t p, int idx);
    pipe_t       r;
    logic [19:0] prod;
    logic [3:0]  digit;
    logic [15:0] rem;
    r     = p;
    digit = 4'd0;
    rem   = p.rem;
    for (int j = 1; j <= 9; j++) begin
      prod = 20'(j * int'(POW10[idx]));
      if ({4'b0, p.rem} >= prod) begin
        digit = 4'(j);
        rem   = 16'({4'b0, p.rem} - prod);
      end
    end
    r.rem                          = rem;
    r.digits[NUM_DIGITS - 1 - idx] = digit;
    return r;
  endfunction

endpackage

// ===== rtl/sdf_emit.sv =====
// Character assembly stage and one-character-per-cycle output serializer.
module sdf_emit
  import sdf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  pipe_t in_data,
  output logic  in_ready,
  output logic  strobe,
  output rsp_t  result
);

  function automatic fmt_t fmt_build(pipe_t p);
    fmt_t       f;
    logic [2:0] cnt;
    logic       started;
    logic [2:0] ppos;
    logic [3:0] d;
    f.chars = {MAX_CHARS{CH_ZERO}};
    cnt     = 3'd0;
    started = 1'b0;
    ppos    = 3'd5;
    d       = 4'd0;
    if (p.zero) begin
      f.chars[0] = CH_ZERO;
      cnt        = 3'd1;
    end else begin
      if (p.places >= 3'd1 && p.places <= 3'd4) ppos = 3'(3'd5 - p.places);
      if (p.neg) begin
        f.chars[cnt] = CH_MINUS;
        cnt          = cnt + 3'd1;
      end
      for (int k = 0; k < NUM_DIGITS; k++) begin
        d = p.digits[NUM_DIGITS - 1 - k];
        if (3'(k) == ppos) begin
          if (!started && cnt != 3'(MAX_CHARS)) begin
            f.chars[cnt] = CH_ZERO;
            cnt          = cnt + 3'd1;
          end
          if (cnt != 3'(MAX_CHARS)) begin
            f.chars[cnt] = CH_POINT;
            cnt          = cnt + 3'd1;
          end
          started = 1'b1;
        end
        if (d != 4'd0 || started || k == NUM_DIGITS - 1) begin
          if (cnt != 3'(MAX_CHARS)) begin
            f.chars[cnt] = CH_ZERO + 7'(d);
            cnt          = cnt + 3'd1;
          end
          started = 1'b1;
        end
      end
    end
    f.last = cnt - 3'd1;
    return f;
  endfunction

  logic       fmt_valid;
  fmt_t       fmt;
  logic       ser_valid;
  logic [MAX_CHARS-1:0][6:0] ser_buf;
  logic [2:0] ser_rem;
  logic       ser_take;

  // serializer frees up on its final char of a string
  assign ser_take = !ser_valid || ser_rem == 3'd0;
  assign in_ready = !fmt_valid || ser_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_valid <= 1'b0;
    end else if (in_ready) begin
      fmt_valid <= in_valid;
    end
    if (in_ready) fmt <= fmt_build(in_data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
    end else if (ser_take) begin
      ser_valid <= fmt_valid;
    end
    if (ser_take) begin
      ser_buf <= fmt.chars;
      ser_rem <= fmt.last;
    end else begin
      ser_buf <= ser_buf >> 7;
      ser_rem <= ser_rem - 3'd1;
    end
  end

  assign strobe           = ser_valid;
  assign result.char_code = ser_buf[0];
  assign result.last_char = ser_rem == 3'd0;

endmodule

// ===== rtl/signed_decimal_formatter_with_point.sv =====
// Top level: signed 16-bit value to ASCII decimal with optional decimal point.
//
//   channel   direction  handshake                 payload
//   request   in         start high, busy low      request (req_t)
//   result    out        strobe, one cycle each    result (rsp_t)
//
// A request yields 1 to 7 characters, one per cycle; the serializer's one-char-per-cycle
// output sets the sustained request rate, as each request holds it for as long as its string lasts.
// The first character reaches the result ports through the entry and five digit stages, one
// assembly stage, then the serializer, each registered; a busy serializer can stall them.
// Requests queue in the pipeline meanwhile.
// Synchronous reset clears all valid bits; the result side never stalls, busy only
// reflects a full pipeline behind the serializer.
module signed_decimal_formatter_with_point
  import sdf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic strobe,
  output rsp_t result
);

  pipe_t                  pipe [NUM_DIGITS+1];
  logic [NUM_DIGITS:0]    pipe_valid;
  logic [NUM_DIGITS+1:0]  stage_ready;
  logic                   emit_ready;
  logic                   accept;

  assign stage_ready[NUM_DIGITS+1] = emit_ready;
  for (genvar k = 0; k <= NUM_DIGITS; k++) begin : g_ready
    assign stage_ready[k] = !pipe_valid[k] || stage_ready[k+1];
  end

  assign busy   = !stage_ready[0];
  assign accept = start && !busy;

  // entry stage: sign and magnitude (-32768 maps to 32768 unsigned)
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid[0] <= 1'b0;
    end else if (stage_ready[0]) begin
      pipe_valid[0] <= accept;
    end
    if (stage_ready[0]) begin
      pipe[0].neg    <= request.value[15];
      pipe[0].zero   <= request.value == 16'sd0;
      pipe[0].places <= request.point_places;
      pipe[0].rem    <= request.value[15] ? 16'(-request.value) : 16'(request.value);
      pipe[0].digits <= '0;
    end
  end

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe_valid[k+1] <= 1'b0;
      end else if (stage_ready[k+1]) begin
        pipe_valid[k+1] <= pipe_valid[k];
      end
      if (stage_ready[k+1]) pipe[k+1] <= digit_step(pipe[k], k);
    end
  end

  sdf_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pipe_valid[NUM_DIGITS]),
    .in_data  (pipe[NUM_DIGITS]),
    .in_ready (emit_ready),
    .strobe   (strobe),
    .result   (result)
  );

  // a string never breaks off before its last char
  a_string_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_char |=> strobe)
    else $error("result string cut short");

  // a taken request lands in the entry stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    accept |=> pipe_valid[0])
    else $error("accepted request lost at entry");

  // magnitude never exceeds 32768, so the top digit is at most 3
  a_top_digit: assert property (@(posedge clk) disable iff (rst)
    pipe_valid[NUM_DIGITS] |-> pipe[NUM_DIGITS].digits[NUM_DIGITS-1] <= 4'd3)
    else $error("ten-thousands digit out of range");

endmodule

// ===== tb/sdf_char_checker.sv =====
// Checker for the decimal formatter: predicts each request's characters and compares results.
module sdf_char_checker
  import sdf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t request,
  input  logic strobe,
  input  rsp_t result,
  output int   errors,
  output int   pending
);

  rsp_t expected_chars[$];

  // Spell out one request as the characters it must produce, oldest first.
  task automatic predict_chars(input req_t r);
    rsp_t        line[MAX_CHARS];
    int          n;
    int          point_at;
    int          d;
    bit          lead;
    logic [16:0] mag;
    int          weight[NUM_DIGITS] = '{10000, 1000, 100, 10, 1};
    n    = 0;
    lead = 1'b0;
    if (r.value == 16'sd0) begin
      // zero ignores the point count entirely
      line[0] = '{char_code: CH_ZERO, last_char: 1'b0};
      n = 1;
    end else begin
      point_at = (r.point_places >= 3'd1 && r.point_places <= 3'd4) ?
                 NUM_DIGITS - int'(r.point_places) : NUM_DIGITS;
      // 17 bits so that the most negative value keeps its magnitude
      mag = r.value[15] ? 17'h10000 - {1'b0, r.value} : {1'b0, r.value};
      if (r.value[15]) begin
        line[n] = '{char_code: CH_MINUS, last_char: 1'b0};
        n++;
      end
      for (int k = 0; k < NUM_DIGITS; k++) begin
        d = (int'(mag) / weight[k]) % 10;
        if (k == point_at) begin
          if (!lead) begin
            line[n] = '{char_code: CH_ZERO, last_char: 1'b0};
            n++;
          end
          line[n] = '{char_code: CH_POINT, last_char: 1'b0};
          n++;
          lead = 1'b1;
        end
        if (d != 0 || lead || k == NUM_DIGITS - 1) begin
          line[n] = '{char_code: 7'(int'(CH_ZERO) + d), last_char: 1'b0};
          n++;
          lead = 1'b1;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      line[i].last_char = (i == n - 1);
      expected_chars.push_back(line[i]);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      errors  <= 0;
      pending <= 0;
    end else begin
      if (start && !busy) predict_chars(request);
      if (strobe) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char: expected none, got char %h last %b",
                   $time, result.char_code, result.last_char);
          errors <= errors + 1;
        end else begin
          want = expected_chars.pop_front();
          if (result.char_code !== want.char_code || result.last_char !== want.last_char) begin
            $display("%0t: char mismatch: expected char %h last %b, got char %h last %b",
                     $time, want.char_code, want.last_char, result.char_code, result.last_char);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_chars.size();
    end
  end

endmodule

// ===== tb/tb_signed_decimal_formatter_with_point.sv =====
// Testbench top: drives requests into the decimal formatter in bursts and reports the verdict.
module tb_signed_decimal_formatter_with_point
  import sdf_pkg::*;
;

  localparam int RANDOM_REQS = 160;
  localparam int QUIET_LIMIT = 2000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic strobe;
  rsp_t result;
  int   errors;
  int   pending;
  int   quiet_cycles;

  signed_decimal_formatter_with_point dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  sdf_char_checker chk (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ends the run if neither side moves for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("signed_decimal_formatter_with_point regression: fail");
        $finish;
      end
    end
  end

  // Present a request and return at the edge that takes it.
  task automatic issue_number(input logic signed [15:0] v, input logic [2:0] places);
    bit taken;
    start   <= 1'b1;
    request <= '{value: v, point_places: places};
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic go_quiet(input int cycles);
    start   <= 1'b0;
    request <= req_t'(19'($urandom));
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_value();
    logic signed [15:0] v;
    logic signed [15:0] extremes[7] = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768,
                                        16'sd10000, -16'sd10000};
    case ($urandom_range(0, 3))
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(0, 120));
      2: v = 16'($urandom_range(1, 9) * extremes[5] / (10 ** $urandom_range(0, 4)));
      default: v = extremes[$urandom_range(0, 6)];
    endcase
    if ($urandom_range(0, 1) == 1 && v != -16'sd32768) v = -v;
    return v;
  endfunction

  function automatic logic [2:0] pick_places();
    return ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
  endfunction

  initial begin
    int sent;
    int burst;
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero with places, point padding, out-of-range places
    issue_number(16'sd0, 3'd3);
    issue_number(16'sd0, 3'd0);
    issue_number(16'sd32767, 3'd0);
    issue_number(-16'sd32768, 3'd0);
    issue_number(-16'sd32768, 3'd2);
    issue_number(-16'sd32768, 3'd4);
    issue_number(16'sd32767, 3'd4);
    issue_number(-16'sd1, 3'd4);
    issue_number(16'sd1, 3'd4);
    issue_number(16'sd5, 3'd1);
    issue_number(-16'sd5, 3'd1);
    issue_number(16'sd50, 3'd1);
    issue_number(16'sd12345, 3'd4);
    issue_number(16'sd100, 3'd2);
    issue_number(16'sd99, 3'd2);
    issue_number(16'sd10, 3'd3);
    issue_number(16'sd1000, 3'd3);
    issue_number(-16'sd10000, 3'd0);
    issue_number(16'sd7, 3'd5);
    issue_number(-16'sd7, 3'd7);
    issue_number(16'sd20304, 3'd6);
    issue_number(-16'sd21846, 3'd1);
    drain_results();

    sent = 0;
    while (sent < RANDOM_REQS) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) begin
        issue_number(pick_value(), pick_places());
        sent++;
      end
      if (sent >= RANDOM_REQS / 2 && sent - burst < RANDOM_REQS / 2) begin
        drain_results();
      end else if ($urandom_range(0, 3) != 0) begin
        go_quiet($urandom_range(1, 15));
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (pending != 0) $display("%0t: %0d expected chars never arrived", $time, pending);
    if (errors == 0 && pending == 0) begin
      $display("signed_decimal_formatter_with_point regression: pass");
    end else begin
      $display("signed_decimal_formatter_with_point regression: fail");
    end
    $finish;
  end

endmodule
